@@ design/bbq_pkg.sv @@
// bbq_pkg: shared types and codes for the byte budget backpressure queue
// used by the core, the arithmetic unit and the port checker
package bbq_pkg;

  localparam int unsigned CMD_W       = 2;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned TAG_W       = 16;
  localparam int unsigned SIZE_W      = 32;
  localparam int unsigned PROD_W      = 8;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 128;
  localparam int unsigned OUT_PAD_W   = 6;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CHUNK_W     = TAG_W + SIZE_W;
  localparam int unsigned PARK_W      = PROD_W + TAG_W + SIZE_W;

  localparam logic [SIZE_W-1:0] BUDGET_RST = 32'd1048576;
  localparam logic [SIZE_W-1:0] LOW_RST    = 32'd524288;

  localparam logic [CFG_IDX_W-1:0] REG_BYTE_BUDGET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_WATER   = 1'b1;

  localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SCAN    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNBLOCK = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

  localparam logic [KIND_W-1:0] KIND_ACCEPTED   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PARKED     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REFUSED    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CHUNK_OUT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STREAM_END = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RELEASED   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_DONE       = 3'd6;

  typedef enum logic [0:0] {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e           op;
    logic [SIZE_W-1:0] a;
    logic [SIZE_W-1:0] b;
    logic [SIZE_W-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [SIZE_W-1:0] res;
    logic              flag;
  } alu_rsp_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
    logic [PROD_W-1:0] prod;
    logic [SIZE_W-1:0] held;
    logic [SIZE_W-1:0] peak;
    logic              sat;
    logic              parked;
    logic              last;
  } res_t;

endpackage

@@ design/byte_budget_backpressure_queue_core.sv @@
// byte_budget_backpressure_queue_core: chunk queue with byte budget and parked producer fifo
// depends on bbq_pkg, bbq_alu, bbq_ram
//
//  channel  | direction | handshake               | payload
//  s_axis   | in        | tvalid/tready           | tuser command, tdata tag/size/producer
//  m_axis   | out       | tvalid/tready, tlast    | tuser kind, tdata result fields
//  cfg      | in        | cfg_we_i, no wait       | cfg_idx_i, cfg_data_i
//
// one item at a time; the byte sums, differences and compares go through the one shared
// 33-bit unit, and tready stays low until the item is done; each parked producer released
// passes through park read, fit check, peak, budget compare and staging.
// each result is staged one step before it reaches the output register so tlast is known.
// the output register is stalled by m_axis_tready only; a new item may be taken while
// the final result of the previous one still waits there.
// reset restores state, counters, pointers, flags and limits; the ram is never cleared.
module byte_budget_backpressure_queue_core #(
  parameter int unsigned CHUNK_DEPTH = 64,
  parameter int unsigned PARK_DEPTH  = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tag [15:0], size [47:16], producer [55:48]
  input  logic [bbq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // command [1:0]
  input  logic [bbq_pkg::CMD_W-1:0]          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tag [15:0], size [47:16], producer [55:48], held [87:56], peak [119:88],
  // saturated [120], any_parked [121], zero [127:122]
  output logic [bbq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // kind [2:0]
  output logic [bbq_pkg::KIND_W-1:0]         m_axis_tuser,
  output logic                               m_axis_tlast,
  input  logic                               cfg_we_i,
  input  logic [bbq_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bbq_pkg::SIZE_W-1:0]         cfg_data_i
);

  localparam int unsigned CAW = $clog2(CHUNK_DEPTH);
  localparam int unsigned CFW = $clog2(CHUNK_DEPTH + 1);
  localparam int unsigned CSW = CFW + 1;
  localparam int unsigned PAW = (PARK_DEPTH > 1) ? $clog2(PARK_DEPTH) : 1;
  localparam int unsigned PFW = $clog2(PARK_DEPTH + 1);
  localparam int unsigned PSW = PFW + 1;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_APP     = 4'd1;
  localparam logic [3:0] S_SCAN    = 4'd2;
  localparam logic [3:0] S_SCAN_RD = 4'd3;
  localparam logic [3:0] S_LW      = 4'd4;
  localparam logic [3:0] S_UNB     = 4'd5;
  localparam logic [3:0] S_REL_RD  = 4'd6;
  localparam logic [3:0] S_REL_FIT = 4'd7;
  localparam logic [3:0] S_PEAK    = 4'd8;
  localparam logic [3:0] S_SAT     = 4'd9;
  localparam logic [3:0] S_SNAP    = 4'd10;
  localparam logic [3:0] S_FIN     = 4'd11;

  logic [3:0] state_q, state_d;

  logic [bbq_pkg::CMD_W-1:0]  cmd_q, cmd_d;
  logic [bbq_pkg::TAG_W-1:0]  tag_q, tag_d;
  logic [bbq_pkg::SIZE_W-1:0] size_q, size_d;
  logic [bbq_pkg::PROD_W-1:0] prod_q, prod_d;

  logic [bbq_pkg::SIZE_W-1:0] budget_q, low_q;
  logic [bbq_pkg::SIZE_W-1:0] held_q, held_d;
  logic [bbq_pkg::SIZE_W-1:0] peak_q, peak_d;
  logic                       closed_q, closed_d;
  logic                       rel_q, rel_d;
  logic                       sat_q, sat_d;
  logic [CAW-1:0]             chead_q, chead_d;
  logic [CFW-1:0]             cfill_q, cfill_d;
  logic [PAW-1:0]             phead_q, phead_d;
  logic [PFW-1:0]             pfill_q, pfill_d;

  logic [bbq_pkg::KIND_W-1:0] rkind_q, rkind_d;
  logic [bbq_pkg::TAG_W-1:0]  rtag_q, rtag_d;
  logic [bbq_pkg::SIZE_W-1:0] rsize_q, rsize_d;
  logic [bbq_pkg::PROD_W-1:0] rprod_q, rprod_d;

  bbq_pkg::res_t pend_q, pend_d;
  logic          pend_v_q, pend_v_d;
  bbq_pkg::res_t out_q, out_d;
  logic          out_v_q, out_v_d;

  bbq_pkg::alu_req_t alu_req;
  bbq_pkg::alu_rsp_t alu_rsp;

  logic                         c_we, c_re;
  logic [CAW-1:0]               c_tail;
  logic [bbq_pkg::CHUNK_W-1:0]  c_wdata, c_rdata;
  logic                         p_we, p_re;
  logic [PAW-1:0]               p_tail;
  logic [bbq_pkg::PARK_W-1:0]   p_wdata, p_rdata;

  logic out_free;
  logic accept;
  logic fit;
  logic chunk_room;
  logic park_room;

  bbq_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  bbq_ram #(
    .WIDTH (bbq_pkg::CHUNK_W),
    .DEPTH (CHUNK_DEPTH)
  ) u_chunk_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_tail),
    .wdata_i (c_wdata),
    .re_i    (c_re),
    .raddr_i (chead_q),
    .rdata_o (c_rdata)
  );

  bbq_ram #(
    .WIDTH (bbq_pkg::PARK_W),
    .DEPTH (PARK_DEPTH)
  ) u_park_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_tail),
    .wdata_i (p_wdata),
    .re_i    (p_re),
    .raddr_i (phead_q),
    .rdata_o (p_rdata)
  );

  // ring tails: head plus fill, wrapped once
  always_comb begin
    logic [CSW-1:0] csum;
    logic [PSW-1:0] psum;
    csum = CSW'(chead_q) + CSW'(cfill_q);
    if (csum >= CSW'(CHUNK_DEPTH)) begin
      csum = csum - CSW'(CHUNK_DEPTH);
    end
    c_tail = csum[CAW-1:0];
    psum = PSW'(phead_q) + PSW'(pfill_q);
    if (psum >= PSW'(PARK_DEPTH)) begin
      psum = psum - PSW'(PARK_DEPTH);
    end
    p_tail = psum[PAW-1:0];
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_v_q || m_axis_tready;
  assign chunk_room    = (cfill_q < CFW'(CHUNK_DEPTH));
  assign park_room     = (pfill_q < PFW'(PARK_DEPTH));
  assign fit           = (held_q == '0) || alu_rsp.flag;

  // shared unit operand selection
  always_comb begin
    alu_req.op = bbq_pkg::ALU_SUB;
    alu_req.a  = held_q;
    alu_req.b  = budget_q;
    alu_req.c  = budget_q;
    unique case (state_q)
      S_APP: begin
        alu_req.op = bbq_pkg::ALU_ADD;
        alu_req.b  = size_q;
      end
      S_SCAN_RD: alu_req.b = c_rdata[bbq_pkg::SIZE_W-1:0];
      S_LW:      alu_req.b = low_q;
      S_REL_FIT: begin
        alu_req.op = bbq_pkg::ALU_ADD;
        alu_req.b  = p_rdata[bbq_pkg::SIZE_W-1:0];
      end
      S_PEAK: begin
        alu_req.a = peak_q;
        alu_req.b = held_q;
      end
      default: alu_req.a = held_q;
    endcase
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    tag_d    = tag_q;
    size_d   = size_q;
    prod_d   = prod_q;
    held_d   = held_q;
    peak_d   = peak_q;
    closed_d = closed_q;
    rel_d    = rel_q;
    sat_d    = sat_q;
    chead_d  = chead_q;
    cfill_d  = cfill_q;
    phead_d  = phead_q;
    pfill_d  = pfill_q;
    rkind_d  = rkind_q;
    rtag_d   = rtag_q;
    rsize_d  = rsize_q;
    rprod_d  = rprod_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    out_d    = out_q;
    out_v_d  = out_v_q && !m_axis_tready;
    c_we     = 1'b0;
    c_re     = 1'b0;
    c_wdata  = {tag_q, size_q};
    p_we     = 1'b0;
    p_re     = 1'b0;
    p_wdata  = {prod_q, tag_q, size_q};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d   = s_axis_tuser;
          tag_d   = s_axis_tdata[15:0];
          size_d  = s_axis_tdata[47:16];
          prod_d  = s_axis_tdata[55:48];
          rel_d   = 1'b0;
          rtag_d  = '0;
          rsize_d = '0;
          rprod_d = '0;
          unique case (s_axis_tuser)
            bbq_pkg::CMD_APPEND:  state_d = S_APP;
            bbq_pkg::CMD_SCAN:    state_d = S_SCAN;
            bbq_pkg::CMD_UNBLOCK: state_d = S_UNB;
            default: begin
              rkind_d = bbq_pkg::KIND_DONE;
              state_d = S_SAT;
            end
          endcase
        end
      end
      S_APP: begin
        if (fit && chunk_room) begin
          c_we    = 1'b1;
          held_d  = alu_rsp.res;
          cfill_d = cfill_q + CFW'(1);
          rkind_d = bbq_pkg::KIND_ACCEPTED;
          state_d = S_PEAK;
        end else if (park_room) begin
          p_we    = 1'b1;
          pfill_d = pfill_q + PFW'(1);
          rkind_d = bbq_pkg::KIND_PARKED;
          state_d = S_SAT;
        end else begin
          rkind_d = bbq_pkg::KIND_REFUSED;
          state_d = S_SAT;
        end
      end
      S_SCAN: begin
        if (closed_q) begin
          rkind_d = bbq_pkg::KIND_STREAM_END;
          state_d = S_SAT;
        end else if (cfill_q == '0) begin
          closed_d = 1'b1;
          rkind_d  = bbq_pkg::KIND_STREAM_END;
          state_d  = S_SAT;
        end else begin
          c_re    = 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        held_d  = alu_rsp.res;
        rtag_d  = c_rdata[bbq_pkg::CHUNK_W-1:bbq_pkg::SIZE_W];
        rsize_d = c_rdata[bbq_pkg::SIZE_W-1:0];
        rkind_d = bbq_pkg::KIND_CHUNK_OUT;
        chead_d = (chead_q == CAW'(CHUNK_DEPTH - 1)) ? '0 : chead_q + CAW'(1);
        cfill_d = cfill_q - CFW'(1);
        state_d = S_LW;
      end
      S_LW: begin
        rel_d   = alu_rsp.flag;
        state_d = S_SAT;
      end
      S_UNB: begin
        if (alu_rsp.flag) begin
          state_d = S_REL_RD;
        end else begin
          rkind_d = bbq_pkg::KIND_DONE;
          state_d = S_SAT;
        end
      end
      S_REL_RD: begin
        if (pfill_q != '0) begin
          p_re    = 1'b1;
          state_d = S_REL_FIT;
        end else if (cmd_q == bbq_pkg::CMD_UNBLOCK) begin
          rkind_d = bbq_pkg::KIND_DONE;
          rtag_d  = '0;
          rsize_d = '0;
          rprod_d = '0;
          state_d = S_SAT;
        end else begin
          state_d = S_FIN;
        end
      end
      S_REL_FIT: begin
        c_wdata = p_rdata[bbq_pkg::CHUNK_W-1:0];
        if (fit && chunk_room) begin
          c_we    = 1'b1;
          held_d  = alu_rsp.res;
          cfill_d = cfill_q + CFW'(1);
          phead_d = (phead_q == PAW'(PARK_DEPTH - 1)) ? '0 : phead_q + PAW'(1);
          pfill_d = pfill_q - PFW'(1);
          rkind_d = bbq_pkg::KIND_RELEASED;
          rtag_d  = p_rdata[bbq_pkg::CHUNK_W-1:bbq_pkg::SIZE_W];
          rsize_d = p_rdata[bbq_pkg::SIZE_W-1:0];
          rprod_d = p_rdata[bbq_pkg::PARK_W-1:bbq_pkg::CHUNK_W];
          state_d = S_PEAK;
        end else if (cmd_q == bbq_pkg::CMD_UNBLOCK) begin
          rkind_d = bbq_pkg::KIND_DONE;
          rtag_d  = '0;
          rsize_d = '0;
          rprod_d = '0;
          state_d = S_SAT;
        end else begin
          state_d = S_FIN;
        end
      end
      S_PEAK: begin
        if (alu_rsp.flag) begin
          peak_d = held_q;
        end
        state_d = S_SAT;
      end
      S_SAT: begin
        sat_d   = !alu_rsp.flag;
        state_d = S_SNAP;
      end
      S_SNAP: begin
        // the staged result goes out as not-last once a newer one exists
        if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            out_d   = pend_q;
            out_v_d = 1'b1;
          end
          pend_d.kind   = rkind_q;
          pend_d.tag    = rtag_q;
          pend_d.size   = rsize_q;
          pend_d.prod   = rprod_q;
          pend_d.held   = held_q;
          pend_d.peak   = peak_q;
          pend_d.sat    = sat_q || (pfill_q != '0);
          pend_d.parked = (pfill_q != '0);
          pend_d.last   = 1'b0;
          pend_v_d      = 1'b1;
          if ((rkind_q == bbq_pkg::KIND_RELEASED) ||
              ((rkind_q == bbq_pkg::KIND_CHUNK_OUT) && rel_q)) begin
            state_d = S_REL_RD;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_d      = pend_q;
          out_d.last = 1'b1;
          out_v_d    = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      held_q   <= '0;
      peak_q   <= '0;
      closed_q <= 1'b0;
      rel_q    <= 1'b0;
      sat_q    <= 1'b0;
      chead_q  <= '0;
      cfill_q  <= '0;
      phead_q  <= '0;
      pfill_q  <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      budget_q <= bbq_pkg::BUDGET_RST;
      low_q    <= bbq_pkg::LOW_RST;
    end else begin
      state_q  <= state_d;
      held_q   <= held_d;
      peak_q   <= peak_d;
      closed_q <= closed_d;
      rel_q    <= rel_d;
      sat_q    <= sat_d;
      chead_q  <= chead_d;
      cfill_q  <= cfill_d;
      phead_q  <= phead_d;
      pfill_q  <= pfill_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          bbq_pkg::REG_BYTE_BUDGET: budget_q <= cfg_data_i;
          bbq_pkg::REG_LOW_WATER:   low_q    <= cfg_data_i;
          default:                  low_q    <= low_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    tag_q   <= tag_d;
    size_q  <= size_d;
    prod_q  <= prod_d;
    rkind_q <= rkind_d;
    rtag_q  <= rtag_d;
    rsize_q <= rsize_d;
    rprod_q <= rprod_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {{bbq_pkg::OUT_PAD_W{1'b0}}, out_q.parked, out_q.sat, out_q.peak,
                          out_q.held, out_q.prod, out_q.size, out_q.tag};

endmodule

@@ design/bbq_ram.sv @@
// bbq_ram: generic single write port ram with registered read
// no dependencies
module bbq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/bbq_alu.sv @@
// bbq_alu: shared 33-bit add/compare and saturating subtract unit
// depends on bbq_pkg
module bbq_alu (
  input  bbq_pkg::alu_req_t req_i,
  output bbq_pkg::alu_rsp_t rsp_o
);

  logic [bbq_pkg::SIZE_W:0] sum;
  logic [bbq_pkg::SIZE_W:0] diff;

  always_comb begin
    sum  = {1'b0, req_i.a} + {1'b0, req_i.b};
    diff = {1'b0, req_i.a} - {1'b0, req_i.b};
    case (req_i.op)
      bbq_pkg::ALU_ADD: begin
        // full precision sum against the limit
        rsp_o.res  = sum[bbq_pkg::SIZE_W-1:0];
        rsp_o.flag = (sum <= {1'b0, req_i.c});
      end
      default: begin
        // flag is the borrow, a < b; result clamps at zero
        rsp_o.flag = diff[bbq_pkg::SIZE_W];
        rsp_o.res  = diff[bbq_pkg::SIZE_W] ? '0 : diff[bbq_pkg::SIZE_W-1:0];
      end
    endcase
  end

endmodule

@@ design/bbq_checker.sv @@
// bbq_checker: port level checks for the byte budget backpressure queue core
// depends on bbq_pkg; bound to byte_budget_backpressure_queue_core
module bbq_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bbq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [bbq_pkg::KIND_W-1:0]      m_axis_tuser,
  input logic                            m_axis_tlast
);

  // one item at a time: ready drops right after an item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while previous item still in work");

  // single result kinds always close their item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == bbq_pkg::KIND_ACCEPTED ||
                      m_axis_tuser == bbq_pkg::KIND_PARKED ||
                      m_axis_tuser == bbq_pkg::KIND_REFUSED ||
                      m_axis_tuser == bbq_pkg::KIND_STREAM_END ||
                      m_axis_tuser == bbq_pkg::KIND_DONE) |-> m_axis_tlast)
    else $error("single result item without tlast");

  // peak never below the held byte count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[119:88] >= m_axis_tdata[87:56])
    else $error("peak below held bytes");

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind byte_budget_backpressure_queue_core bbq_checker u_bbq_checker (.*);

@@ tb/sv/bbq_result_checker.sv @@
`timescale 1ns / 1ps
// bbq_result_checker: watches the item and result streams of the queue core, predicts
// every result from its own model of the byte budget queue and compares them in order
// depends on bbq_pkg
module bbq_result_checker #(
  parameter int unsigned CHUNK_DEPTH = 64,
  parameter int unsigned PARK_DEPTH  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  // tag [15:0], size [47:16], producer [55:48]
  input  logic [bbq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // command [1:0]
  input  logic [bbq_pkg::CMD_W-1:0]       s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tag [15:0], size [47:16], producer [55:48], held [87:56], peak [119:88],
  // saturated [120], any_parked [121], zero [127:122]
  input  logic [bbq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // kind [2:0]
  input  logic [bbq_pkg::KIND_W-1:0]      m_axis_tuser,
  input  logic                            m_axis_tlast,
  input  logic                            cfg_we_i,
  input  logic [bbq_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bbq_pkg::SIZE_W-1:0]      cfg_data_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o,
  output int unsigned                     queued_chunks_o
);

  logic [bbq_pkg::SIZE_W-1:0]  budget_q;
  logic [bbq_pkg::SIZE_W-1:0]  low_water_q;
  logic [bbq_pkg::SIZE_W-1:0]  held_q;
  logic [bbq_pkg::SIZE_W-1:0]  peak_q;
  logic                        closed_q;
  logic [bbq_pkg::CHUNK_W-1:0] chunk_mem [CHUNK_DEPTH];
  logic [bbq_pkg::PARK_W-1:0]  park_mem [PARK_DEPTH];
  int unsigned                 chunk_rd;
  int unsigned                 chunk_cnt;
  int unsigned                 park_rd;
  int unsigned                 park_cnt;
  bbq_pkg::res_t               pending_results [$];

  // an empty queue takes anything, otherwise the sum is compared at 33 bits
  function automatic logic room_for(input logic [bbq_pkg::SIZE_W-1:0] size);
    return (held_q == '0) || (({1'b0, held_q} + {1'b0, size}) <= {1'b0, budget_q});
  endfunction

  task automatic queue_result(input logic [bbq_pkg::KIND_W-1:0] kind,
                              input logic [bbq_pkg::TAG_W-1:0] tag,
                              input logic [bbq_pkg::SIZE_W-1:0] size,
                              input logic [bbq_pkg::PROD_W-1:0] prod);
    bbq_pkg::res_t r;
    r.kind   = kind;
    r.tag    = tag;
    r.size   = size;
    r.prod   = prod;
    r.held   = held_q;
    r.peak   = peak_q;
    r.sat    = (held_q >= budget_q) || (park_cnt != 0);
    r.parked = (park_cnt != 0);
    r.last   = 1'b0;
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic store_chunk(input logic [bbq_pkg::TAG_W-1:0] tag,
                             input logic [bbq_pkg::SIZE_W-1:0] size);
    chunk_mem[(chunk_rd + chunk_cnt) % CHUNK_DEPTH] = {tag, size};
    chunk_cnt++;
    held_q = held_q + size;
    if (held_q > peak_q) peak_q = held_q;
  endtask

  // park entries are {producer, tag, size}; stop at the first misfit or a full chunk queue
  task automatic wake_parked();
    logic [bbq_pkg::PARK_W-1:0] entry;
    logic                       going;
    going = 1'b1;
    while (going && park_cnt != 0) begin
      entry = park_mem[park_rd];
      if (!room_for(entry[bbq_pkg::SIZE_W-1:0]) || chunk_cnt >= CHUNK_DEPTH) begin
        going = 1'b0;
      end else begin
        park_rd = (park_rd + 1) % PARK_DEPTH;
        park_cnt--;
        store_chunk(entry[bbq_pkg::CHUNK_W-1:bbq_pkg::SIZE_W], entry[bbq_pkg::SIZE_W-1:0]);
        queue_result(bbq_pkg::KIND_RELEASED, entry[bbq_pkg::CHUNK_W-1:bbq_pkg::SIZE_W],
                     entry[bbq_pkg::SIZE_W-1:0], entry[bbq_pkg::PARK_W-1:bbq_pkg::CHUNK_W]);
      end
    end
  endtask

  task automatic predict_item(input logic [bbq_pkg::CMD_W-1:0] cmd,
                              input logic [bbq_pkg::TAG_W-1:0] tag,
                              input logic [bbq_pkg::SIZE_W-1:0] size,
                              input logic [bbq_pkg::PROD_W-1:0] prod);
    logic [bbq_pkg::CHUNK_W-1:0] head;
    bbq_pkg::res_t               tail;
    case (cmd)
      bbq_pkg::CMD_APPEND: begin
        if (room_for(size) && chunk_cnt < CHUNK_DEPTH) begin
          store_chunk(tag, size);
          queue_result(bbq_pkg::KIND_ACCEPTED, '0, '0, '0);
        end else if (park_cnt < PARK_DEPTH) begin
          park_mem[(park_rd + park_cnt) % PARK_DEPTH] = {prod, tag, size};
          park_cnt++;
          queue_result(bbq_pkg::KIND_PARKED, '0, '0, '0);
        end else begin
          queue_result(bbq_pkg::KIND_REFUSED, '0, '0, '0);
        end
      end
      bbq_pkg::CMD_SCAN: begin
        if (closed_q) begin
          queue_result(bbq_pkg::KIND_STREAM_END, '0, '0, '0);
        end else if (chunk_cnt == 0) begin
          closed_q = 1'b1;
          queue_result(bbq_pkg::KIND_STREAM_END, '0, '0, '0);
        end else begin
          head     = chunk_mem[chunk_rd];
          chunk_rd = (chunk_rd + 1) % CHUNK_DEPTH;
          chunk_cnt--;
          held_q   = (held_q >= head[bbq_pkg::SIZE_W-1:0]) ?
                     held_q - head[bbq_pkg::SIZE_W-1:0] : '0;
          queue_result(bbq_pkg::KIND_CHUNK_OUT, head[bbq_pkg::CHUNK_W-1:bbq_pkg::SIZE_W],
                       head[bbq_pkg::SIZE_W-1:0], '0);
          if (held_q < low_water_q) wake_parked();
        end
      end
      bbq_pkg::CMD_UNBLOCK: begin
        if (held_q < budget_q) wake_parked();
        queue_result(bbq_pkg::KIND_DONE, '0, '0, '0);
      end
      default: begin
        queue_result(bbq_pkg::KIND_DONE, '0, '0, '0);
      end
    endcase
    tail = pending_results[pending_results.size() - 1];
    tail.last = 1'b1;
    pending_results[pending_results.size() - 1] = tail;
  endtask

  task automatic check_field(input string name, input logic [bbq_pkg::SIZE_W-1:0] want,
                             input logic [bbq_pkg::SIZE_W-1:0] got);
    if (got !== want) begin
      fail_count_o++;
      $display("%0t: result %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bbq_pkg::res_t want;
    if (!rst_ni) begin
      budget_q        = bbq_pkg::BUDGET_RST;
      low_water_q     = bbq_pkg::LOW_RST;
      held_q          = '0;
      peak_q          = '0;
      closed_q        = 1'b0;
      chunk_rd        = 0;
      chunk_cnt       = 0;
      park_rd         = 0;
      park_cnt        = 0;
      pending_results.delete();
      fail_count_o    = 0;
      pending_o       = 0;
      queued_chunks_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == bbq_pkg::REG_BYTE_BUDGET) budget_q = cfg_data_i;
        else if (cfg_idx_i == bbq_pkg::REG_LOW_WATER) low_water_q = cfg_data_i;
      end
      // a result taken at the same edge as a new item still belongs to an older one
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with none expected: kind %0d, tdata 0x%0h", $time,
                   m_axis_tuser, m_axis_tdata);
        end else begin
          want = pending_results.pop_front();
          check_field("kind", want.kind, m_axis_tuser);
          check_field("tag", want.tag, m_axis_tdata[15:0]);
          check_field("size", want.size, m_axis_tdata[47:16]);
          check_field("producer", want.prod, m_axis_tdata[55:48]);
          check_field("bytes_held", want.held, m_axis_tdata[87:56]);
          check_field("peak_held", want.peak, m_axis_tdata[119:88]);
          check_field("saturated", want.sat, m_axis_tdata[120]);
          check_field("any_parked", want.parked, m_axis_tdata[121]);
          check_field("padding", '0, m_axis_tdata[127:122]);
          check_field("last", want.last, m_axis_tlast);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_item(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[47:16],
                     s_axis_tdata[55:48]);
      end
      pending_o       = pending_results.size();
      queued_chunks_o = chunk_cnt;
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// testbench: drives commands and register writes into the byte budget queue core and
// gives the verdict; result prediction and comparison live in bbq_result_checker
// depends on bbq_pkg, bbq_result_checker and the core
module testbench;

  localparam int unsigned HOLD_OFF_CYCLES = 300;

  typedef enum int unsigned {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE,
    READY_PERIODIC
  } ready_mode_e;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [bbq_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [bbq_pkg::CMD_W-1:0]       s_axis_tuser  = bbq_pkg::CMD_NOP;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [bbq_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [bbq_pkg::KIND_W-1:0]      m_axis_tuser;
  logic                            m_axis_tlast;
  logic                            cfg_we_i      = 1'b0;
  logic [bbq_pkg::CFG_IDX_W-1:0]   cfg_idx_i     = bbq_pkg::REG_BYTE_BUDGET;
  logic [bbq_pkg::SIZE_W-1:0]      cfg_data_i    = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned queued_chunks;
  int unsigned burst_left   = 0;
  logic        hold_off_req = 1'b0;

  always #10 clk_i = ~clk_i;

  byte_budget_backpressure_queue_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  bbq_result_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .m_axis_tlast    (m_axis_tlast),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .queued_chunks_o (queued_chunks)
  );

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_item(input logic [bbq_pkg::CMD_W-1:0] cmd,
                           input logic [bbq_pkg::TAG_W-1:0] tag,
                           input logic [bbq_pkg::SIZE_W-1:0] size,
                           input logic [bbq_pkg::PROD_W-1:0] prod);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {prod, size, tag};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic set_limits(input logic [bbq_pkg::SIZE_W-1:0] budget,
                            input logic [bbq_pkg::SIZE_W-1:0] low);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= bbq_pkg::REG_BYTE_BUDGET;
    cfg_data_i <= budget;
    @(negedge clk_i);
    cfg_idx_i  <= bbq_pkg::REG_LOW_WATER;
    cfg_data_i <= low;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [bbq_pkg::SIZE_W-1:0] pick_size(
      input logic [bbq_pkg::SIZE_W-1:0] cap);
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      3:       return cap + $urandom_range(0, cap);
      default: return $urandom_range(0, cap);
    endcase
  endfunction

  // scans only while chunks are queued so the stream stays open until the end
  task automatic run_phase(input int unsigned count, input int unsigned append_pct,
                           input logic [bbq_pkg::SIZE_W-1:0] cap);
    int unsigned               pick;
    logic [bbq_pkg::CMD_W-1:0] cmd;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < append_pct) cmd = bbq_pkg::CMD_APPEND;
      else if (pick >= 98) cmd = bbq_pkg::CMD_NOP;
      else if (pick >= 92) cmd = bbq_pkg::CMD_UNBLOCK;
      else cmd = bbq_pkg::CMD_SCAN;
      if (cmd == bbq_pkg::CMD_SCAN && queued_chunks == 0) cmd = bbq_pkg::CMD_APPEND;
      send_item(cmd, 16'($urandom_range(0, 65535)), pick_size(cap),
                8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : receiver
    ready_mode_e mode;
    int unsigned left;
    int unsigned phase;
    mode  = READY_ALWAYS;
    left  = 0;
    phase = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = ready_mode_e'($urandom_range(0, 3));
          left = $urandom_range(16, 96);
        end
        left--;
        phase++;
        case (mode)
          READY_ALWAYS: m_axis_tready <= 1'b1;
          READY_HALF:   m_axis_tready <= 1'($urandom_range(0, 1));
          READY_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:      m_axis_tready <= (phase % 4 != 3);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [bbq_pkg::SIZE_W-1:0] budget;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part on the reset settings: 1 MiB budget, 512 KiB low water
    send_item(bbq_pkg::CMD_NOP, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    send_item(bbq_pkg::CMD_APPEND, 16'hFFFF, 32'd0, 8'hFF);
    // a queue holding no bytes admits even a chunk far over budget
    send_item(bbq_pkg::CMD_APPEND, 16'h0000, 32'hFFFF_FFFF, 8'h00);
    send_item(bbq_pkg::CMD_APPEND, 16'h1234, 32'd1, 8'h01);
    // over budget: unblock releases nothing
    send_item(bbq_pkg::CMD_UNBLOCK, 16'h0000, 32'd0, 8'h00);
    send_item(bbq_pkg::CMD_SCAN, 16'h0000, 32'd0, 8'h00);
    send_item(bbq_pkg::CMD_SCAN, 16'h0000, 32'd0, 8'h00);
    send_item(bbq_pkg::CMD_APPEND, 16'h00A1, 32'd300000, 8'h10);
    send_item(bbq_pkg::CMD_APPEND, 16'h00A2, 32'd600000, 8'h11);
    send_item(bbq_pkg::CMD_APPEND, 16'h00A3, 32'd300000, 8'h12);
    send_item(bbq_pkg::CMD_SCAN, 16'h0000, 32'd0, 8'h00);
    send_item(bbq_pkg::CMD_UNBLOCK, 16'h0000, 32'd0, 8'h00);
    send_item(bbq_pkg::CMD_SCAN, 16'h0000, 32'd0, 8'h00);
    // held bytes above low water but under budget: unblock lets the parked chunk in
    send_item(bbq_pkg::CMD_UNBLOCK, 16'h0000, 32'd0, 8'h00);
    send_item(bbq_pkg::CMD_SCAN, 16'h0000, 32'd0, 8'h00);
    send_item(bbq_pkg::CMD_SCAN, 16'h0000, 32'd0, 8'h00);
    // exact fit against the budget
    send_item(bbq_pkg::CMD_APPEND, 16'h5A5A, bbq_pkg::BUDGET_RST, 8'h55);
    send_item(bbq_pkg::CMD_APPEND, 16'hA5A5, 32'd0, 8'hAA);
    send_item(bbq_pkg::CMD_APPEND, 16'h0F0F, 32'd1, 8'h0F);
    send_item(bbq_pkg::CMD_SCAN, 16'h0000, 32'd0, 8'h00);
    send_item(bbq_pkg::CMD_SCAN, 16'h0000, 32'd0, 8'h00);
    send_item(bbq_pkg::CMD_UNBLOCK, 16'h0000, 32'd0, 8'h00);

    wait_idle();
    set_limits(32'd1000000, 32'd300000);
    run_phase(40, 55, 32'd350000);
    // long output stall while items keep coming
    hold_off_req = 1'b1;
    run_phase(40, 55, 32'd350000);

    // huge budget and small chunks: fills the chunk queue so later appends park
    wait_idle();
    set_limits('1, '1);
    run_phase(90, 85, 32'd2000);

    wait_idle();
    set_limits(32'd1, '0);
    run_phase(60, 40, 32'd2);

    wait_idle();
    budget = $urandom_range(1000, 1 << 24);
    set_limits(budget, $urandom_range(0, budget));
    run_phase(40, 55, budget / 3);
    wait_idle();
    run_phase(40, 55, budget / 3);

    wait_idle();
    set_limits('1, '0);
    run_phase(120, 50, 32'h4000_0000);

    // drain, then close the stream and poke it afterwards
    wait_idle();
    set_limits(bbq_pkg::BUDGET_RST, '1);
    while (queued_chunks != 0) begin
      send_item(bbq_pkg::CMD_SCAN, 16'($urandom_range(0, 65535)), $urandom,
                8'($urandom_range(0, 255)));
    end
    send_item(bbq_pkg::CMD_SCAN, 16'h0000, 32'd0, 8'h00);
    send_item(bbq_pkg::CMD_SCAN, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    send_item(bbq_pkg::CMD_APPEND, 16'hBEEF, 32'd4096, 8'h42);
    send_item(bbq_pkg::CMD_UNBLOCK, 16'h0000, 32'd0, 8'h00);
    send_item(bbq_pkg::CMD_NOP, 16'h0000, 32'd0, 8'h00);

    wait_idle();
    repeat (50) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("** byte_budget_backpressure_queue_core: PASSED **");
    end else begin
      $display("** byte_budget_backpressure_queue_core: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #15_000_000;
    $display("** byte_budget_backpressure_queue_core: FAILED **");
    $finish;
  end

endmodule

@@ filelist.f @@
design/bbq_pkg.sv
design/bbq_ram.sv
design/bbq_alu.sv
design/byte_budget_backpressure_queue_core.sv
design/bbq_checker.sv
tb/sv/bbq_result_checker.sv
tb/sv/testbench.sv
